FILE: hw/rtl/adjacency_matrix_dfs_engine_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the adjacency matrix DFS engine
// Implication checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_DFS_ENGINE_TOP_ASSERT_SVH
`define ADJACENCY_MATRIX_DFS_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ADMS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ADMS_ASSERT_IMPL(lbl, ante, cons, msg)
`define ADMS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/adms_pkg.sv
// ----------------------------------------------------------------------------
// adms_pkg
// Shared types, request and status codes, and controller/datapath commands.
// ----------------------------------------------------------------------------
package adms_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int VTX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	localparam logic [2:0] MODE_LOAD   = 3'd0;
	localparam logic [2:0] MODE_INSERT = 3'd1;
	localparam logic [2:0] MODE_DELETE = 3'd2;
	localparam logic [2:0] MODE_SEARCH = 3'd3;
	localparam logic [2:0] MODE_DFS    = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;
	localparam logic [1:0] ST_RANGE   = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  vertex_a;
		logic [5:0]  vertex_b;
		logic [63:0] row_bits;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] vertex;
		logic       last;
	} rsp_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LATCH,
		DP_LOAD,
		DP_RD_A,
		DP_WR_A_RD_B,
		DP_WR_B,
		DP_DFS_INIT,
		DP_PUSH,
		DP_POP,
		DP_TOP,
		DP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       emit;
		logic [1:0] status;
		logic       last;
		logic       use_pend;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       mode_bad;
		logic       range_bad;
		logic       bit_ab;
		logic       found;
		logic       depth_one;
	} dp_stat_t;

endpackage

FILE: hw/rtl/adjacency_matrix_dfs_engine_top.sv
// Steps: load, bad mode and out-of-range requests answer from decode; search and failed
// delete read row A first; insert and delete also write rows A and B. A DFS walk starts,
// pushes each reached vertex, pops each dead end with a stack read, and then finishes.
// Busy drops while the last beat shows, so the next request is accepted at the edge
// that takes that beat; each request holds the engine until its last beat. No stall.
// Reset clears the matrix row valid bits (rows read as zero) and sets vertex_count to 64.
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_engine_top
// Adjacency bit matrix with edge requests and depth-first preorder walk.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_engine_top
	import adms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  req_t             request,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	output logic             strobe,
	output rsp_t             result
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	adms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	adms_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

FILE: hw/rtl/adms_dpath.sv
// ----------------------------------------------------------------------------
// adms_dpath
// Adjacency matrix memory, walk stack, visited map, neighbor encoder and
// the registered result beat.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_dfs_engine_top_assert.svh"

module adms_dpath
	import adms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  req_t             request,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	output logic             strobe,
	output rsp_t             result
);

	localparam logic [MAX_VERTICES-1:0] ROW_ONE = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	req_t                     req_q;
	logic [CNT_W-1:0]         vcount_q;
	logic [CNT_W-1:0]         eff_cnt;
	logic [MAX_VERTICES-1:0]  cnt_mask;

	logic [MAX_VERTICES-1:0]  mat_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]  row_valid_q;
	logic [MAX_VERTICES-1:0]  rd_q;
	logic                     rd_en;
	logic [VTX_W-1:0]         rd_addr;
	logic                     wr_en;
	logic [VTX_W-1:0]         wr_addr;
	logic [MAX_VERTICES-1:0]  wr_data;
	logic [MAX_VERTICES-1:0]  other_bit;

	logic [VTX_W-1:0]         stk_mem [MAX_VERTICES];
	logic [VTX_W-1:0]         stk_rd_q;
	logic                     stk_we;
	logic [VTX_W-1:0]         stk_waddr;
	logic [VTX_W-1:0]         stk_wdata;
	logic [CNT_W-1:0]         depth_q;
	logic [CNT_W-1:0]         depth_m2;

	logic [MAX_VERTICES-1:0]  visited_q;
	logic [MAX_VERTICES-1:0]  cand;
	logic [VTX_W-1:0]         idx;
	logic [VTX_W-1:0]         pend_q;
	logic                     edge_req;

	logic                     strobe_q;
	rsp_t                     result_q;

	// effective vertex count and the scan window it opens
	always_comb begin
		eff_cnt = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			cnt_mask[i] = (CNT_W'(i) < eff_cnt);
		end
	end

	// lowest unvisited neighbor inside the window
	always_comb begin
		cand = rd_q & ~visited_q & cnt_mask;
		idx  = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				idx = VTX_W'(i);
			end
		end
	end

	assign depth_m2 = depth_q - CNT_W'(2);

	always_comb begin
		edge_req = req_q.mode inside {MODE_INSERT, MODE_DELETE, MODE_SEARCH};
		stat.mode      = req_q.mode;
		stat.mode_bad  = (req_q.mode > MODE_DFS);
		stat.range_bad = ({1'b0, req_q.vertex_a} >= eff_cnt) ||
			(edge_req && ({1'b0, req_q.vertex_b} >= eff_cnt));
		stat.bit_ab    = rd_q[req_q.vertex_b];
		stat.found     = |cand;
		stat.depth_one = (depth_q == CNT_W'(1));
	end

	// matrix port control
	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = req_q.vertex_a;
		wr_en     = 1'b0;
		wr_addr   = req_q.vertex_a;
		other_bit = ROW_ONE << req_q.vertex_b;
		case (cmd.op)
			DP_LOAD: begin
				wr_en = 1'b1;
			end
			DP_RD_A, DP_DFS_INIT: begin
				rd_en = 1'b1;
			end
			DP_WR_A_RD_B: begin
				wr_en   = 1'b1;
				rd_en   = 1'b1;
				rd_addr = req_q.vertex_b;
			end
			DP_WR_B: begin
				wr_en     = 1'b1;
				wr_addr   = req_q.vertex_b;
				other_bit = ROW_ONE << req_q.vertex_a;
			end
			DP_PUSH: begin
				rd_en   = 1'b1;
				rd_addr = idx;
			end
			DP_TOP: begin
				rd_en   = 1'b1;
				rd_addr = stk_rd_q;
			end
			default: begin
			end
		endcase
		if (cmd.op == DP_LOAD) begin
			wr_data = req_q.row_bits;
		end else if (req_q.mode == MODE_INSERT) begin
			wr_data = rd_q | other_bit;
		end else begin
			wr_data = rd_q & ~other_bit;
		end
	end

	always_comb begin
		stk_we    = (cmd.op == DP_DFS_INIT) || (cmd.op == DP_PUSH);
		stk_waddr = (cmd.op == DP_PUSH) ? depth_q[VTX_W-1:0] : '0;
		stk_wdata = (cmd.op == DP_PUSH) ? idx : req_q.vertex_a;
	end

	// matrix memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= row_valid_q[rd_addr] ? mat_mem[rd_addr] : '0;
		end
	end

	// walk stack memory
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (cmd.op == DP_POP) begin
			stk_rd_q <= stk_mem[depth_m2[VTX_W-1:0]];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == DP_LATCH) begin
			req_q <= request;
		end
		if (cmd.op == DP_DFS_INIT) begin
			pend_q <= req_q.vertex_a;
		end else if (cmd.op == DP_PUSH) begin
			pend_q <= idx;
		end
		if (cmd.emit) begin
			result_q.status <= cmd.status;
			result_q.vertex <= cmd.use_pend ? pend_q : '0;
			result_q.last   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= CNT_W'(MAX_VERTICES);
			row_valid_q <= '0;
			depth_q     <= '0;
			visited_q   <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
			if (cfg_we) begin
				vcount_q <= cfg_wdata;
			end
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			case (cmd.op)
				DP_DFS_INIT: begin
					depth_q   <= CNT_W'(1);
					visited_q <= ROW_ONE << req_q.vertex_a;
				end
				DP_PUSH: begin
					depth_q   <= depth_q + CNT_W'(1);
					visited_q <= visited_q | (ROW_ONE << idx);
				end
				DP_POP: begin
					depth_q <= depth_q - CNT_W'(1);
				end
				DP_FINISH: begin
					depth_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`ADMS_ASSERT_IMPL(a_push_room, cmd.op == DP_PUSH, depth_q < CNT_W'(MAX_VERTICES), "push on full walk stack")
	`ADMS_ASSERT_NEXT(a_push_marks, cmd.op == DP_PUSH, visited_q[$past(idx)], "pushed vertex not marked visited")

endmodule

FILE: hw/rtl/adms_ctrl.sv
// ----------------------------------------------------------------------------
// adms_ctrl
// Request sequencer: decodes a request, steps the matrix read-modify-write
// and drives the depth-first walk push and pop steps.
// ----------------------------------------------------------------------------
`include "adjacency_matrix_dfs_engine_top_assert.svh"

module adms_ctrl
	import adms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EDGE_CHK,
		S_EDGE_WR_B,
		S_DFS_SCAN,
		S_DFS_TOP
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd.op       = DP_NOP;
		cmd.emit     = 1'b0;
		cmd.status   = ST_DONE;
		cmd.last     = 1'b0;
		cmd.use_pend = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = DP_LATCH;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.mode_bad) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end else if (stat.range_bad) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_RANGE;
					cmd.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					case (stat.mode)
						MODE_LOAD: begin
							cmd.op   = DP_LOAD;
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							state_d  = S_IDLE;
						end
						MODE_INSERT, MODE_DELETE, MODE_SEARCH: begin
							cmd.op  = DP_RD_A;
							state_d = S_EDGE_CHK;
						end
						MODE_DFS: begin
							cmd.op  = DP_DFS_INIT;
							state_d = S_DFS_SCAN;
						end
						default: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							state_d  = S_IDLE;
						end
					endcase
				end
			end
			S_EDGE_CHK: begin
				if (stat.mode == MODE_SEARCH) begin
					cmd.emit   = 1'b1;
					cmd.status = stat.bit_ab ? ST_PRESENT : ST_ABSENT;
					cmd.last   = 1'b1;
					state_d    = S_IDLE;
				end else if (stat.mode == MODE_DELETE && !stat.bit_ab) begin
					cmd.emit   = 1'b1;
					cmd.status = ST_ABSENT;
					cmd.last   = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.op  = DP_WR_A_RD_B;
					state_d = S_EDGE_WR_B;
				end
			end
			S_EDGE_WR_B: begin
				cmd.op   = DP_WR_B;
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				state_d  = S_IDLE;
			end
			S_DFS_SCAN: begin
				// each visit is held as pending and sent by a later push or the finish, so the final one can carry last
				if (stat.found) begin
					cmd.op       = DP_PUSH;
					cmd.emit     = 1'b1;
					cmd.use_pend = 1'b1;
				end else if (stat.depth_one) begin
					cmd.op       = DP_FINISH;
					cmd.emit     = 1'b1;
					cmd.use_pend = 1'b1;
					cmd.last     = 1'b1;
					state_d      = S_IDLE;
				end else begin
					cmd.op  = DP_POP;
					state_d = S_DFS_TOP;
				end
			end
			S_DFS_TOP: begin
				cmd.op  = DP_TOP;
				state_d = S_DFS_SCAN;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	`ADMS_ASSERT_IMPL(a_idle_quiet, state_q == S_IDLE, !cmd.emit, "result beat from idle state")
	`ADMS_ASSERT_NEXT(a_last_ends, cmd.emit && cmd.last, state_q == S_IDLE, "request kept running past its last beat")

endmodule
